FILE: design/pgalloc_pkg.sv
// Shared constants and types for the page allocator.
package pgalloc_pkg;

    localparam int PAGES  = 64;
    localparam int PAGE_W = $clog2(PAGES);
    localparam int CNT_W  = $clog2(PAGES + 1);

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIT_STRATEGY = 1'b0;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_FREE_LEN = 6'b000100,
        S_FREE_CLR = 6'b001000,
        S_CLAIM    = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

endpackage

FILE: design/page_allocator_fit_strategies.sv
// Page allocator top level: page map, length store, scan sequencer and APB register.
//
// One item at a time. An allocate goes from S_IDLE to S_SCAN, a page-map scan
// (one page per cycle through a single run counter and compare unit; first and
// next fit stop at the first hit, best and worst fit always scan all PAGES
// pages), then to S_CLAIM, which marks the chosen pages one by one, then to
// S_FINISH, which posts the result. An allocate with zero or oversized length
// goes from S_IDLE straight to S_FINISH. A free reads the stored block length in
// S_FREE_LEN, releases the pages one by one in S_FREE_CLR and posts in S_FINISH.
// req_ready is high only between items; a posted result waits in the output
// register and the next item can be taken while it waits.
module page_allocator_fit_strategies
    import pgalloc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        command,
    input  logic [6:0]  request_length,
    input  logic [5:0]  free_start,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [5:0]  start_page
);

    state_t              state_reg, state_next;
    logic [PAGES-1:0]    page_used_reg, page_used_next;
    logic [PAGES-1:0]    len_valid_reg, len_valid_next;
    logic [PAGE_W-1:0]   rover_reg, rover_next;
    logic [1:0]          strategy_reg;
    logic [PAGE_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PAGE_W-1:0]   run_start_reg, run_start_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    best_len_reg, best_len_next;
    logic [PAGE_W-1:0]   best_start_reg, best_start_next;
    logic [CNT_W-1:0]    req_len_reg, req_len_next;
    logic                free_ok_reg, free_ok_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [PAGE_W-1:0]   res_start_reg, res_start_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [5:0]          out_start_reg, out_start_next;

    logic [CNT_W-1:0]    len_mem [PAGES];
    logic [CNT_W-1:0]    len_rd_reg;
    logic                mem_we;
    logic [PAGE_W-1:0]   mem_wa;
    logic [CNT_W-1:0]    mem_wd;
    logic                mem_re;
    logic [PAGE_W-1:0]   mem_ra;

    logic                cfg_wr;
    logic                pg_free;
    logic                last_pg;
    logic [CNT_W-1:0]    cnt_inc;
    logic [PAGE_W-1:0]   run_start_new;
    logic                hit;
    logic                cand_ok;
    logic [CNT_W-1:0]    cand_n;
    logic [PAGE_W-1:0]   cand_s;
    logic                better;
    logic                size_mode;
    logic                len_ok;
    logic [CNT_W-1:0]    free_n;

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIT_STRATEGY);
    assign prdata = (paddr[2] == REG_FIT_STRATEGY) ? {30'd0, strategy_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= FIT_FIRST;
        end
        else if (cfg_wr)
        begin
            strategy_reg <= pwdata[1:0];
        end
    end

    // Block length store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            len_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            len_rd_reg <= len_mem[mem_ra];
        end
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = out_status_reg;
    assign start_page = out_start_reg;

    // Shared scan unit
    assign size_mode     = (strategy_reg == FIT_BEST) || (strategy_reg == FIT_WORST);
    assign pg_free       = !page_used_reg[pos_reg];
    assign last_pg       = (pos_reg == PAGE_W'(PAGES - 1));
    assign cnt_inc       = cnt_reg + CNT_W'(1);
    assign run_start_new = (cnt_reg == '0) ? pos_reg : run_start_reg;
    assign hit           = !size_mode && pg_free && (cnt_inc == req_len_reg);

    always_comb
    begin
        cand_ok = 1'b0;
        cand_n  = cnt_reg;
        cand_s  = run_start_reg;
        if (!pg_free && (cnt_reg != '0))
        begin
            cand_ok = 1'b1;
        end
        else if (pg_free && last_pg)
        begin
            cand_ok = 1'b1;
            cand_n  = cnt_inc;
            cand_s  = run_start_new;
        end
    end

    assign better = size_mode && cand_ok && (cand_n >= req_len_reg) &&
                    (!found_reg ||
                     ((strategy_reg == FIT_WORST) ? (cand_n > best_len_reg)
                                                  : (cand_n < best_len_reg)));

    assign len_ok = (request_length != 7'd0) && (32'(request_length) <= PAGES);
    assign free_n = len_valid_reg[pos_reg] ? len_rd_reg : CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        page_used_next  = page_used_reg;
        len_valid_next  = len_valid_reg;
        rover_next      = rover_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        req_len_next    = req_len_reg;
        free_ok_next    = free_ok_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        mem_we          = 1'b0;
        mem_wa          = best_start_reg;
        mem_wd          = req_len_reg;
        mem_re          = 1'b0;
        mem_ra          = PAGE_W'(free_start);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_start_next = '0;
                    if (command == CMD_FREE)
                    begin
                        mem_re          = 1'b1;
                        pos_next        = PAGE_W'(free_start);
                        free_ok_next    = (32'(free_start) < PAGES);
                        res_status_next = ST_FREED;
                        state_next      = S_FREE_LEN;
                    end
                    else if (!len_ok)
                    begin
                        res_status_next = ST_NO_SPACE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        req_len_next  = CNT_W'(request_length);
                        step_next     = '0;
                        cnt_next      = '0;
                        found_next    = 1'b0;
                        best_len_next = '0;
                        if ((strategy_reg == FIT_NEXT) &&
                            (rover_reg < PAGE_W'(PAGES - 1)))
                        begin
                            pos_next = rover_reg;
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                cnt_next       = (pg_free && !last_pg) ? cnt_inc : '0;
                run_start_next = run_start_new;
                pos_next       = last_pg ? '0 : pos_reg + PAGE_W'(1);
                step_next      = step_reg + CNT_W'(1);
                if (better)
                begin
                    found_next      = 1'b1;
                    best_len_next   = cand_n;
                    best_start_next = cand_s;
                end
                if (hit)
                begin
                    best_start_next = run_start_new;
                    state_next      = S_CLAIM;
                end
                else if (step_reg == CNT_W'(PAGES - 1))
                begin
                    state_next = (found_reg || better) ? S_CLAIM : S_FINISH;
                end
                if (state_next == S_CLAIM)
                begin
                    pos_next = best_start_next;
                    cnt_next = req_len_reg;
                end
                else if (state_next == S_FINISH)
                begin
                    res_status_next = ST_NO_SPACE;
                end
            end

            S_FREE_LEN:
            begin
                if (free_ok_reg)
                begin
                    len_valid_next[pos_reg] = 1'b0;
                    cnt_next                = free_n;
                    state_next              = S_FREE_CLR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FREE_CLR:
            begin
                page_used_next[pos_reg] = 1'b0;
                if ((cnt_reg == CNT_W'(1)) || last_pg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    pos_next = pos_reg + PAGE_W'(1);
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            S_CLAIM:
            begin
                page_used_next[pos_reg] = 1'b1;
                if (pos_reg == best_start_reg)
                begin
                    mem_we                         = 1'b1;
                    len_valid_next[best_start_reg] = 1'b1;
                end
                if ((cnt_reg == CNT_W'(1)) || last_pg)
                begin
                    if (strategy_reg == FIT_NEXT)
                    begin
                        rover_next = best_start_reg;
                    end
                    res_status_next = ST_ALLOCATED;
                    res_start_next  = best_start_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    pos_next = pos_reg + PAGE_W'(1);
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = 6'(res_start_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            page_used_reg <= '0;
            len_valid_reg <= '0;
            rover_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_used_reg <= page_used_next;
            len_valid_reg <= len_valid_next;
            rover_reg     <= rover_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        run_start_reg  <= run_start_next;
        found_reg      <= found_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        req_len_reg    <= req_len_next;
        free_ok_reg    <= free_ok_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

endmodule
